### rtl/cib_pkg.sv
`default_nettype none
package cib_pkg;

	// Saturation limits of the size registers
	localparam int MAX_FRAME_WIDTH  = 128;
	localparam int MAX_FRAME_HEIGHT = 64;
	localparam int MAX_IMAGE_DIM    = 256;

	// Queue between front and back, and result queue
	localparam int MID_DEPTH = 4;
	localparam int MID_AW    = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW    = 2;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_FRAME_WIDTH     = 3'd0,
		REG_FRAME_HEIGHT    = 3'd1,
		REG_SRC_WIDTH       = 3'd2,
		REG_SRC_HEIGHT      = 3'd3,
		REG_BYTES_PER_PIXEL = 3'd4,
		REG_DEST_X          = 3'd5,
		REG_DEST_Y          = 3'd6
	} reg_idx_t;

	// Pixel size codes that draw something
	localparam logic [2:0] BPP_GRAY = 3'd1;
	localparam logic [2:0] BPP_RGB  = 3'd3;
	localparam logic [2:0] BPP_RGBA = 3'd4;

	// Effective (saturated) configuration
	typedef struct packed {
		logic [7:0]        frame_width;
		logic [6:0]        frame_height;
		logic [8:0]        src_width;
		logic [8:0]        src_height;
		logic [2:0]        bytes_per_pixel;
		logic signed [9:0] dest_x;
		logic signed [9:0] dest_y;
	} cfg_t;

	// Assembled pixel handed from front to back
	typedef struct packed {
		logic [7:0]  col;
		logic [7:0]  row;
		logic [23:0] color;
		logic        last;
	} pix_t;

	// Handshake of the middle queue
	typedef struct packed {
		logic valid;
		pix_t head;
	} mid_t;

	// Clipped result
	typedef struct packed {
		logic [12:0] pixel_index;
		logic [23:0] color;
		logic        visible;
		logic        last_pixel;
	} res_t;

endpackage
`default_nettype wire

### rtl/clipped_image_blit.sv
// Path: a byte that completes a pixel is written to the middle queue, then to the
// clip stage register, then to the result queue, whose head drives the result ports.
// Throughput: one byte per cycle while full is low; one result per cycle while the
// result queue has room, bounded by the clip stage with its single 6x8 multiply.
// Reset: arst_n clears queues, counters and color holds and loads the register
// reset values at once; no clearing pass.
`default_nettype none
module clipped_image_blit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [9:0]  cfg_wdata,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [12:0]      pixel_index,
	output logic [23:0]      color,
	output logic             visible,
	output logic             last_pixel
);

	cib_pkg::cfg_t cfg;
	cib_pkg::mid_t mid;
	cib_pkg::res_t res;
	logic          mid_pop;

	cib_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cib_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.mid_pop   (mid_pop),
		.mid       (mid)
	);

	cib_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.mid     (mid),
		.mid_pop (mid_pop),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign pixel_index = res.pixel_index;
	assign color       = res.color;
	assign visible     = res.visible;
	assign last_pixel  = res.last_pixel;

	// Clipped pixels carry index zero
	a_invis_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !visible |-> pixel_index == 13'd0)
		else $error("invisible beat with nonzero index");

	// Visible pixels land inside the frame buffer
	a_vis_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && visible |-> 15'(pixel_index) <
			15'(cfg.frame_width) * 15'(cfg.frame_height))
		else $error("visible beat outside frame");

	// The middle queue never drains while the front side is still full
	a_mid_pop: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> mid.valid)
		else $error("front full with empty middle queue");

endmodule
`default_nettype wire

### rtl/cib_cfg.sv
`default_nettype none
module cib_cfg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [9:0]          cfg_wdata,
	output cib_pkg::cfg_t            cfg
);

	logic [7:0] frame_width_q;
	logic [6:0] frame_height_q;
	logic [8:0] src_width_q;
	logic [8:0] src_height_q;
	logic [2:0] bytes_per_pixel_q;
	logic [9:0] dest_x_q;
	logic [9:0] dest_y_q;

	// Register file, writes outside the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q     <= 8'd128;
			frame_height_q    <= 7'd64;
			src_width_q       <= '0;
			src_height_q      <= '0;
			bytes_per_pixel_q <= 3'd3;
			dest_x_q          <= '0;
			dest_y_q          <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cib_pkg::REG_FRAME_WIDTH:     frame_width_q     <= cfg_wdata[7:0];
				cib_pkg::REG_FRAME_HEIGHT:    frame_height_q    <= cfg_wdata[6:0];
				cib_pkg::REG_SRC_WIDTH:       src_width_q       <= cfg_wdata[8:0];
				cib_pkg::REG_SRC_HEIGHT:      src_height_q      <= cfg_wdata[8:0];
				cib_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel_q <= cfg_wdata[2:0];
				cib_pkg::REG_DEST_X:          dest_x_q          <= cfg_wdata;
				cib_pkg::REG_DEST_Y:          dest_y_q          <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Saturate sizes to the supported maxima
	always_comb begin
		cfg.frame_width = (frame_width_q > 8'(cib_pkg::MAX_FRAME_WIDTH)) ?
			8'(cib_pkg::MAX_FRAME_WIDTH) : frame_width_q;
		cfg.frame_height = (frame_height_q > 7'(cib_pkg::MAX_FRAME_HEIGHT)) ?
			7'(cib_pkg::MAX_FRAME_HEIGHT) : frame_height_q;
		cfg.src_width = (src_width_q > 9'(cib_pkg::MAX_IMAGE_DIM)) ?
			9'(cib_pkg::MAX_IMAGE_DIM) : src_width_q;
		cfg.src_height = (src_height_q > 9'(cib_pkg::MAX_IMAGE_DIM)) ?
			9'(cib_pkg::MAX_IMAGE_DIM) : src_height_q;
		cfg.bytes_per_pixel = bytes_per_pixel_q;
		cfg.dest_x = $signed(dest_x_q);
		cfg.dest_y = $signed(dest_y_q);
	end

endmodule
`default_nettype wire

### rtl/cib_front.sv
`default_nettype none
module cib_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cib_pkg::cfg_t cfg,
	input  wire logic          push,
	output logic               full,
	input  wire logic [7:0]    data_byte,
	input  wire logic          mid_pop,
	output cib_pkg::mid_t      mid
);

	logic [1:0] chan_q;
	logic [7:0] col_q;
	logic [7:0] row_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;

	logic [1:0] chan_d;
	logic [7:0] red_d;
	logic [7:0] green_d;
	logic [7:0] blue_d;
	logic       done;
	logic       fmt_ok;
	logic       accept;
	logic       row_end;
	logic       last;
	logic [8:0] col_inc;
	logic [8:0] row_inc;
	logic       mid_push;

	cib_pkg::pix_t             mem_q [cib_pkg::MID_DEPTH];
	logic [cib_pkg::MID_AW-1:0] wr_ptr_q;
	logic [cib_pkg::MID_AW-1:0] rd_ptr_q;
	logic [cib_pkg::MID_AW:0]   count_q;

	assign fmt_ok = (cfg.bytes_per_pixel == cib_pkg::BPP_GRAY ||
		cfg.bytes_per_pixel == cib_pkg::BPP_RGB ||
		cfg.bytes_per_pixel == cib_pkg::BPP_RGBA) &&
		cfg.src_width != '0 && cfg.src_height != '0;
	assign full   = count_q == (cib_pkg::MID_AW+1)'(cib_pkg::MID_DEPTH);
	assign accept = push && !full;

	// Channel assembly
	always_comb begin
		red_d   = red_q;
		green_d = green_q;
		blue_d  = blue_q;
		chan_d  = chan_q;
		done    = 1'b0;
		if (cfg.bytes_per_pixel == cib_pkg::BPP_GRAY) begin
			red_d   = data_byte;
			green_d = data_byte;
			blue_d  = data_byte;
			chan_d  = '0;
			done    = 1'b1;
		end else begin
			case (chan_q)
				2'd0:    red_d   = data_byte;
				2'd1:    green_d = data_byte;
				2'd2:    blue_d  = data_byte;
				default: ;
			endcase
			if ({1'b0, chan_q} + 3'd1 < cfg.bytes_per_pixel) begin
				chan_d = chan_q + 2'd1;
			end else begin
				chan_d = '0;
				done   = 1'b1;
			end
		end
	end

	// Position bookkeeping; a counter past the size ends its row or column
	assign col_inc = {1'b0, col_q} + 9'd1;
	assign row_inc = {1'b0, row_q} + 9'd1;
	assign row_end = col_inc >= cfg.src_width;
	assign last    = row_end && row_inc >= cfg.src_height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else if (accept && fmt_ok) begin
			chan_q  <= chan_d;
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
			if (done) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= last ? 8'd0 : row_inc[7:0];
				end else begin
					col_q <= col_inc[7:0];
				end
			end
		end
	end

	// Middle queue
	assign mid_push = accept && fmt_ok && done;

	always_ff @(posedge clk) begin
		if (mid_push) begin
			mem_q[wr_ptr_q] <= '{col: col_q, row: row_q,
				color: {red_d, green_d, blue_d}, last: last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (mid_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (mid_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (cib_pkg::MID_AW+1)'(mid_push)
				- (cib_pkg::MID_AW+1)'(mid_pop);
		end
	end

	assign mid.valid = count_q != '0;
	assign mid.head  = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

### rtl/cib_back.sv
`default_nettype none
module cib_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cib_pkg::cfg_t cfg,
	input  wire cib_pkg::mid_t mid,
	output logic               mid_pop,
	output logic               empty,
	input  wire logic          pop,
	output cib_pkg::res_t      res
);

	logic signed [10:0] x;
	logic signed [10:0] y;
	logic               vis;
	logic [13:0]        prod;
	logic [12:0]        idx;

	cib_pkg::res_t res_s1;
	logic          valid_s1;
	logic          move_s1;
	logic          out_full;
	logic          out_pop;

	cib_pkg::res_t              mem_q [cib_pkg::OUT_DEPTH];
	logic [cib_pkg::OUT_AW-1:0] wr_ptr_q;
	logic [cib_pkg::OUT_AW-1:0] rd_ptr_q;
	logic [cib_pkg::OUT_AW:0]   count_q;

	// Place at destination and clip against the frame
	assign x   = 11'(cfg.dest_x) + $signed({3'b000, mid.head.col});
	assign y   = 11'(cfg.dest_y) + $signed({3'b000, mid.head.row});
	assign vis = !x[10] && !y[10] && x[9:0] < {2'b00, cfg.frame_width} &&
		y[9:0] < {3'b000, cfg.frame_height};
	assign prod = 14'(y[5:0]) * 14'(cfg.frame_width);
	assign idx  = vis ? 13'(prod + 14'(x[6:0])) : 13'd0;

	// Stage register
	assign move_s1 = valid_s1 && !out_full;
	assign mid_pop = mid.valid && (!valid_s1 || move_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (mid_pop) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			res_s1 <= '{pixel_index: idx, color: mid.head.color, visible: vis,
				last_pixel: mid.head.last};
		end
	end

	// Result queue
	assign out_full = count_q == (cib_pkg::OUT_AW+1)'(cib_pkg::OUT_DEPTH);
	assign empty    = count_q == '0;
	assign out_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (move_s1) mem_q[wr_ptr_q] <= res_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (move_s1) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (out_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (cib_pkg::OUT_AW+1)'(move_s1)
				- (cib_pkg::OUT_AW+1)'(out_pop);
		end
	end

	assign res = mem_q[rd_ptr_q];

endmodule
`default_nettype wire
